// ----- rtl/fat12_cluster_chain_walker_top_assert.svh -----
// Assertion macros for the FAT12 chain walker RTL (used by fcw_walker).
// Needs clk_i and rst_ni in the scope of each use.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FCW_ASSERT(lbl, prop, msg)
`define FCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/fcw_pkg.sv -----
// Types, codes and defaults for the FAT12 cluster chain walker.
// No dependencies.
package fcw_pkg;

  localparam int unsigned TABLE_BYTES_DEF = 6144;
  localparam int unsigned MAX_CHAIN_DEF   = 64;

  localparam int unsigned TBL_IDX_W  = 13;
  localparam int unsigned CLUSTER_W  = 12;
  localparam int unsigned SECTOR_W   = 20;
  localparam int unsigned FDS_W      = 16;
  localparam int unsigned SPC_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_SECTOR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_CLUSTER = 1'd1;

  localparam logic [FDS_W-1:0] FDS_RESET = 16'd33;
  localparam logic [SPC_W-1:0] SPC_RESET = 8'd1;

  localparam logic [CLUSTER_W-1:0] LINK_END_MIN = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] LINK_BAD_MIN = 12'hFF0;
  localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_WALK  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LINK_ERR = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [TBL_IDX_W-1:0] table_byte_index;
    logic [7:0]           table_byte_value;
    logic [CLUSTER_W-1:0] start_cluster;
  } in_item_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [SECTOR_W-1:0]  data_sector;
    logic                 last;
    status_e              status;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [TBL_IDX_W-1:0] waddr;
    logic [7:0]           wdata;
    logic                 re;
    logic [TBL_IDX_W-1:0] raddr_lo;
    logic [TBL_IDX_W-1:0] raddr_hi;
  } tbl_req_t;

endpackage

// ----- rtl/fat12_cluster_chain_walker_top.sv -----
// Table write: written at the transfer; next item taken in the following cycle.
// Walk: each cluster passes through S_READ (dual-port table read) then S_EVAL (link
// decode and output load); an output stall holds the walk in S_EVAL.
// After the last result is loaded the walker returns to idle and takes the next item.
// Start cluster below two: a single error result is loaded from S_BAD.
// Reset: control idle, first_data_sector 33, sectors_per_cluster 1, table undefined.
module fat12_cluster_chain_walker_top #(
  parameter int unsigned TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
  parameter int unsigned MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  fcw_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fcw_pkg::out_item_t             out_data_o
);
  import fcw_pkg::*;

  tbl_req_t   tbl_req;
  logic [7:0] rdata_lo;
  logic [7:0] rdata_hi;

  fcw_table_mem #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_table (
    .clk_i     (clk_i),
    .req_i     (tbl_req),
    .rdata_lo_o(rdata_lo),
    .rdata_hi_o(rdata_hi)
  );

  fcw_walker #(
    .TABLE_BYTES(TABLE_BYTES),
    .MAX_CHAIN  (MAX_CHAIN)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .tbl_req_o  (tbl_req),
    .rdata_lo_i (rdata_lo),
    .rdata_hi_i (rdata_hi)
  );

endmodule

// ----- rtl/fcw_table_mem.sv -----
// Allocation table store: one write port, two registered read ports.
// Depends on fcw_pkg.
module fcw_table_mem #(
  parameter int unsigned TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF
) (
  input  logic              clk_i,
  input  fcw_pkg::tbl_req_t req_i,
  output logic [7:0]        rdata_lo_o,
  output logic [7:0]        rdata_hi_o
);
  import fcw_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_BYTES);

  logic [7:0] mem_q [TABLE_BYTES];
  logic [7:0] rdata_lo_q;
  logic [7:0] rdata_hi_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_lo_q <= mem_q[req_i.raddr_lo[AW-1:0]];
      rdata_hi_q <= mem_q[req_i.raddr_hi[AW-1:0]];
    end
  end

  assign rdata_lo_o = rdata_lo_q;
  assign rdata_hi_o = rdata_hi_q;

endmodule

// ----- rtl/fcw_walker.sv -----
// Command decode, chain walk sequencer, sector arithmetic and output register.
// Depends on fcw_pkg and the assertion macro header.
`include "fat12_cluster_chain_walker_top_assert.svh"

module fcw_walker #(
  parameter int unsigned TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
  parameter int unsigned MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fcw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fcw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  fcw_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fcw_pkg::out_item_t                 out_data_o,
  output fcw_pkg::tbl_req_t                  tbl_req_o,
  input  logic [7:0]                         rdata_lo_i,
  input  logic [7:0]                         rdata_hi_i
);
  import fcw_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHAIN + 1);
  localparam int unsigned PW = TBL_IDX_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_BAD  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CLUSTER_W-1:0] cur_c_q, cur_c_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [FDS_W-1:0]     fds_q;
  logic [SPC_W-1:0]     spc_q;
  logic [SECTOR_W-1:0]  prod_q;
  logic                 lo_oob_q;
  logic                 hi_oob_q;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q;

  logic                 out_free;
  logic                 out_load;
  out_item_t            res;
  tbl_req_t             tbl_req;
  logic [PW-1:0]        c3;
  logic [PW-1:0]        pos;
  logic [PW-1:0]        pos1;
  logic [PW-1:0]        widx;
  logic [CLUSTER_W-1:0] cm2;
  logic [SECTOR_W-1:0]  prod;
  logic [SECTOR_W:0]    sum;
  logic [SECTOR_W-1:0]  sector;
  logic [7:0]           lo_byte;
  logic [7:0]           hi_byte;
  logic [CLUSTER_W-1:0] link;
  logic                 link_end;
  logic                 link_bad;
  logic                 chain_full;

  assign c3   = PW'({cur_c_q, 1'b0}) + PW'(cur_c_q);
  assign pos  = c3 >> 1;
  assign pos1 = pos + PW'(1);
  assign widx = PW'(in_data_i.table_byte_index);

  assign cm2  = cur_c_q - FIRST_DATA_CLUSTER;
  assign prod = SECTOR_W'(cm2) * SECTOR_W'(spc_q);
  assign sum  = (SECTOR_W + 1)'(fds_q) + (SECTOR_W + 1)'(prod_q);
  assign sector = sum[SECTOR_W] ? {SECTOR_W{1'b1}} : sum[SECTOR_W-1:0];

  assign lo_byte = lo_oob_q ? 8'd0 : rdata_lo_i;
  assign hi_byte = hi_oob_q ? 8'd0 : rdata_hi_i;
  assign link    = cur_c_q[0] ? {hi_byte, lo_byte[7:4]} : {hi_byte[3:0], lo_byte};

  assign link_end   = link >= LINK_END_MIN;
  assign link_bad   = (link < FIRST_DATA_CLUSTER) || (link >= LINK_BAD_MIN);
  assign chain_full = cnt_q == CW'(MAX_CHAIN - 1);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d          = state_q;
    cur_c_d          = cur_c_q;
    cnt_d            = cnt_q;
    out_load         = 1'b0;
    res.cluster      = cur_c_q;
    res.data_sector  = sector;
    res.last         = 1'b0;
    res.status       = ST_OK;
    tbl_req.we       = 1'b0;
    tbl_req.waddr    = in_data_i.table_byte_index;
    tbl_req.wdata    = in_data_i.table_byte_value;
    tbl_req.re       = 1'b0;
    tbl_req.raddr_lo = pos[TBL_IDX_W-1:0];
    tbl_req.raddr_hi = pos1[TBL_IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == CMD_WRITE) begin
            tbl_req.we = widx < PW'(TABLE_BYTES);
          end else begin
            cur_c_d = in_data_i.start_cluster;
            cnt_d   = '0;
            state_d = (in_data_i.start_cluster < FIRST_DATA_CLUSTER) ? S_BAD : S_READ;
          end
        end
      end
      S_READ: begin
        tbl_req.re = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          out_load = 1'b1;
          priority if (link_end) begin
            res.last = 1'b1;
            state_d  = S_IDLE;
          end else if (link_bad) begin
            res.last   = 1'b1;
            res.status = ST_LINK_ERR;
            state_d    = S_IDLE;
          end else if (chain_full) begin
            res.last   = 1'b1;
            res.status = ST_TRUNC;
            state_d    = S_IDLE;
          end else begin
            cur_c_d = link;
            cnt_d   = cnt_q + CW'(1);
            state_d = S_READ;
          end
        end
      end
      S_BAD: begin
        res.data_sector = '0;
        res.last        = 1'b1;
        res.status      = ST_LINK_ERR;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_c_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      fds_q       <= FDS_RESET;
      spc_q       <= SPC_RESET;
    end else begin
      state_q     <= state_d;
      cur_c_q     <= cur_c_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FIRST_DATA_SECTOR:   fds_q <= cfg_wdata_i;
          CFG_SECTORS_PER_CLUSTER: spc_q <= cfg_wdata_i[SPC_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      prod_q   <= prod;
      lo_oob_q <= pos >= PW'(TABLE_BYTES);
      hi_oob_q <= pos1 >= PW'(TABLE_BYTES);
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign tbl_req_o   = tbl_req;

  `FCW_ASSERT(a_rw_excl, !(tbl_req.we && tbl_req.re), "table read and write in one cycle")
  `FCW_ASSERT(a_cnt_bound, cnt_q <= CW'(MAX_CHAIN - 1), "walk count beyond chain limit")
  `FCW_ASSERT(a_last_idle, (out_load && res.last) |=> state_q == S_IDLE, "walk continues after last")
  `FCW_ASSERT(a_walk_clus, (state_q == S_READ) |-> cur_c_q >= FIRST_DATA_CLUSTER, "read of cluster below two")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the FAT12 cluster chain walker: a directed table, then random chains
// laid into the allocation table and walked, results checked against the table or a predictor.
// Depends on fcw_pkg and fat12_cluster_chain_walker_top.
module tb;
  import fcw_pkg::*;

  localparam int unsigned FAT_BYTES   = TABLE_BYTES_DEF;
  localparam int unsigned CHAIN_MAX   = MAX_CHAIN_DEF;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DIR_N       = 25;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  logic [7:0]           fat_img [FAT_BYTES];
  bit                   fat_set [FAT_BYTES];
  int unsigned          first_sector = 32'(FDS_RESET);
  int unsigned          sec_per_clu  = 32'(SPC_RESET);
  out_item_t            chain_visits_q [$];
  logic [CLUSTER_W-1:0] chain_heads [$];
  dir_row_t             dir_rows [DIR_N];
  out_item_t            due_visit;
  int                   fails    = 0;
  int unsigned          item_cnt = 0;
  int unsigned          quiet    = 0;
  bit                   idle_on  = 1'b1;
  bit                   stall_on = 1'b1;

  fat12_cluster_chain_walker_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial forever #5 clk = ~clk;

  function automatic logic [7:0] tbl_byte(int unsigned idx);
    if (idx >= FAT_BYTES || !fat_set[idx]) return 8'h00;
    return fat_img[idx];
  endfunction

  function automatic bit byte_known(int unsigned idx);
    return idx >= FAT_BYTES || fat_set[idx];
  endfunction

  function automatic int unsigned entry_pos(logic [CLUSTER_W-1:0] c);
    int unsigned cv;
    cv = 32'(c);
    return (cv * 3) >> 1;
  endfunction

  function automatic logic [CLUSTER_W-1:0] fat_entry(logic [CLUSTER_W-1:0] c);
    logic [7:0]  lo, hi;
    int unsigned pos;
    pos = entry_pos(c);
    lo  = tbl_byte(pos);
    hi  = tbl_byte(pos + 1);
    if (c[0]) return {hi, lo[7:4]};
    return {hi[3:0], lo};
  endfunction

  function automatic logic [SECTOR_W-1:0] cluster_sector(logic [CLUSTER_W-1:0] c);
    int unsigned cv, s;
    cv = 32'(c);
    s  = first_sector + (cv - 2) * sec_per_clu;
    if (s > 32'hFFFFF) s = 32'hFFFFF;
    return s[SECTOR_W-1:0];
  endfunction

  function automatic bit chain_ready(logic [CLUSTER_W-1:0] start);
    logic [CLUSTER_W-1:0] c, nxt;
    int unsigned          pos;
    if (start < FIRST_DATA_CLUSTER) return 1'b1;
    c = start;
    repeat (CHAIN_MAX) begin
      pos = entry_pos(c);
      if (!byte_known(pos) || !byte_known(pos + 1)) return 1'b0;
      nxt = fat_entry(c);
      if (nxt >= LINK_BAD_MIN || nxt < FIRST_DATA_CLUSTER) return 1'b1;
      c = nxt;
    end
    return 1'b1;
  endfunction

  function automatic void follow_chain(logic [CLUSTER_W-1:0] start);
    out_item_t            v;
    logic [CLUSTER_W-1:0] c, nxt;
    if (start < FIRST_DATA_CLUSTER) begin
      v.cluster     = start;
      v.data_sector = '0;
      v.last        = 1'b1;
      v.status      = ST_LINK_ERR;
      chain_visits_q.push_back(v);
      return;
    end
    c = start;
    for (int n = 1; n <= CHAIN_MAX; n++) begin
      nxt           = fat_entry(c);
      v.cluster     = c;
      v.data_sector = cluster_sector(c);
      v.last        = 1'b1;
      v.status      = ST_OK;
      if (nxt >= LINK_BAD_MIN || nxt < FIRST_DATA_CLUSTER) begin
        if (nxt < LINK_END_MIN) v.status = ST_LINK_ERR;
      end else if (n == CHAIN_MAX) begin
        v.status = ST_TRUNC;
      end else begin
        v.last = 1'b0;
      end
      chain_visits_q.push_back(v);
      if (v.last) return;
      c = nxt;
    end
  endfunction

  function automatic void absorb(in_item_t it);
    if (it.cmd == CMD_WRITE) begin
      if (it.table_byte_index < FAT_BYTES) begin
        fat_img[it.table_byte_index] = it.table_byte_value;
        fat_set[it.table_byte_index] = 1'b1;
      end
    end else begin
      follow_chain(it.start_cluster);
    end
  endfunction

  function automatic in_item_t write_item(int unsigned idx, logic [7:0] val);
    in_item_t it;
    it.cmd              = CMD_WRITE;
    it.table_byte_index = idx[TBL_IDX_W-1:0];
    it.table_byte_value = val;
    it.start_cluster    = CLUSTER_W'($urandom_range(0, 4095));
    return it;
  endfunction

  function automatic in_item_t walk_item(logic [CLUSTER_W-1:0] start);
    in_item_t it;
    it.cmd              = CMD_WALK;
    it.table_byte_index = TBL_IDX_W'($urandom_range(0, 8191));
    it.table_byte_value = 8'($urandom_range(0, 255));
    it.start_cluster    = start;
    return it;
  endfunction

  function automatic dir_row_t row(in_item_t it, bit typed, logic [SECTOR_W-1:0] sec,
                                   status_e st);
    dir_row_t r;
    r.item             = it;
    r.typed            = typed;
    r.want.cluster     = it.start_cluster;
    r.want.data_sector = sec;
    r.want.last        = 1'b1;
    r.want.status      = st;
    return r;
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic transfer_cmd(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (it.cmd == CMD_WALK && typed) chain_visits_q.push_back(want);
    else absorb(it);
    if (it.cmd == CMD_WALK || it.table_byte_index < FAT_BYTES) item_cnt++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == CFG_FIRST_DATA_SECTOR) first_sector = 32'(data);
    else sec_per_clu = 32'(data[SPC_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_link(logic [CLUSTER_W-1:0] c, logic [CLUSTER_W-1:0] v);
    int unsigned pos;
    logic [7:0]  lo, hi, b0, b1;
    pos = entry_pos(c);
    lo  = tbl_byte(pos);
    hi  = tbl_byte(pos + 1);
    if (c[0]) begin
      b0 = {v[3:0], lo[3:0]};
      b1 = v[11:4];
    end else begin
      b0 = v[7:0];
      b1 = {hi[7:4], v[11:8]};
    end
    transfer_cmd(write_item(pos, b0));
    transfer_cmd(write_item(pos + 1, b1));
  endtask

  task automatic build_and_walk();
    logic [CLUSTER_W-1:0] nodes [$];
    logic [CLUSTER_W-1:0] c, term;
    int unsigned          len, kind, sel;
    bit                   dup;
    len = $urandom_range(1, 5);
    while (nodes.size() < len) begin
      c   = CLUSTER_W'($urandom_range(2, 12'hFEF));
      dup = 1'b0;
      foreach (nodes[i]) if (nodes[i] == c) dup = 1'b1;
      if (!dup) nodes.push_back(c);
    end
    kind = $urandom_range(0, 5);
    if (kind < 3) begin
      term = CLUSTER_W'($urandom_range(12'hFF8, 12'hFFF));
    end else if (kind < 5) begin
      sel  = $urandom_range(0, 9);
      term = CLUSTER_W'((sel < 2) ? sel : 32'hFF0 + sel - 2);
    end else begin
      term = nodes[$urandom_range(0, len - 1)];
    end
    for (int i = 0; i + 1 < len; i++) set_link(nodes[i], nodes[i + 1]);
    set_link(nodes[len - 1], term);
    transfer_cmd(walk_item(nodes[0]));
    chain_heads.push_back(nodes[0]);
  endtask

  task automatic random_step();
    int unsigned          r;
    logic [CLUSTER_W-1:0] s;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      build_and_walk();
    end else if (r < 88 && r >= 72) begin
      transfer_cmd(write_item($urandom_range(0, 8191), 8'($urandom_range(0, 255))));
    end else begin
      if (r < 72) s = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
      else s = CLUSTER_W'($urandom_range(0, 4095));
      if (!chain_ready(s)) s = CLUSTER_W'($urandom_range(0, 1));
      transfer_cmd(walk_item(s));
    end
  endtask

  initial begin
    int unsigned           target;
    logic [CFG_DATA_W-1:0] fds;
    logic [SPC_W-1:0]      spc;
    dir_rows = '{
      row(walk_item(12'd0),         1'b1, 20'd0,    ST_LINK_ERR),
      row(walk_item(12'd1),         1'b1, 20'd0,    ST_LINK_ERR),
      row(write_item(8191, 8'hFF),  1'b0, 20'd0,    ST_OK),
      row(write_item(6144, 8'h55),  1'b0, 20'd0,    ST_OK),
      row(write_item(0, 8'h00),     1'b0, 20'd0,    ST_OK),
      row(write_item(3, 8'hFF),     1'b0, 20'd0,    ST_OK),
      row(write_item(4, 8'h0F),     1'b0, 20'd0,    ST_OK),
      row(walk_item(12'd2),         1'b1, 20'd33,   ST_OK),
      row(write_item(6143, 8'h00),  1'b0, 20'd0,    ST_OK),
      row(write_item(6142, 8'h00),  1'b0, 20'd0,    ST_OK),
      row(walk_item(12'd4095),      1'b1, 20'd4126, ST_LINK_ERR),
      row(write_item(4, 8'hFF),     1'b0, 20'd0,    ST_OK),
      row(write_item(5, 8'hFF),     1'b0, 20'd0,    ST_OK),
      row(walk_item(12'd3),         1'b1, 20'd34,   ST_OK),
      row(write_item(6142, 8'h70),  1'b0, 20'd0,    ST_OK),
      row(write_item(6143, 8'hFF),  1'b0, 20'd0,    ST_OK),
      row(walk_item(12'd4095),      1'b1, 20'd4126, ST_LINK_ERR),
      row(write_item(6, 8'h05),     1'b0, 20'd0,    ST_OK),
      row(write_item(7, 8'h40),     1'b0, 20'd0,    ST_OK),
      row(write_item(8, 8'h00),     1'b0, 20'd0,    ST_OK),
      row(walk_item(12'd4),         1'b0, 20'd0,    ST_OK),
      row(walk_item(12'd5),         1'b0, 20'd0,    ST_OK),
      row(write_item(9, 8'hF0),     1'b0, 20'd0,    ST_OK),
      row(write_item(10, 8'h0F),    1'b0, 20'd0,    ST_OK),
      row(walk_item(12'd6),         1'b1, 20'd37,   ST_LINK_ERR)
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) transfer_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    chain_heads = '{12'd2, 12'd3, 12'd4};
    for (int p = 0; p < 4; p++) begin
      in_valid <= 1'b0;
      while (chain_visits_q.size() != 0) @(negedge clk);
      repeat (4) @(negedge clk);
      case (p)
        0: begin
          fds = 16'd0;
          spc = 8'd1;
        end
        1: begin
          fds = 16'hFFFF;
          spc = 8'd128;
        end
        default: begin
          fds = CFG_DATA_W'($urandom_range(0, 65535));
          spc = SPC_W'($urandom_range(1, 128));
        end
      endcase
      write_reg(CFG_FIRST_DATA_SECTOR, fds);
      write_reg(CFG_SECTORS_PER_CLUSTER, {8'd0, spc});
      if (p == 3) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      target = item_cnt + 34;
      while (item_cnt < target) random_step();
    end
    in_valid <= 1'b0;
    while (chain_visits_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (chain_visits_q.size() == 0) begin
        $display("%0t: result with none expected: cluster 0x%0h sector 0x%0h last %0d",
                 $time, out_data.cluster, out_data.data_sector, out_data.last);
        fails++;
      end else begin
        due_visit = chain_visits_q.pop_front();
        check_field("cluster", 32'(due_visit.cluster), 32'(out_data.cluster));
        check_field("data_sector", 32'(due_visit.data_sector), 32'(out_data.data_sector));
        check_field("last", 32'(due_visit.last), 32'(out_data.last));
        check_field("status", 32'(due_visit.status), 32'(out_data.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
